// ===== rtl/hs_pkg.sv =====
// ----------------------------------------------------------------------------
// hs_pkg: shared types and constants for the heap sorter
// Item and result structs, store geometry and the RAM write port bundle.
// ----------------------------------------------------------------------------
package hs_pkg;

    localparam int CAPACITY = 64;
    localparam int ADDR_W   = $clog2(CAPACITY);
    localparam int CNT_W    = ADDR_W + 1;
    localparam int WORD_W   = 32;

    typedef logic signed [WORD_W-1:0] t_word;
    typedef logic [ADDR_W-1:0]        t_addr;
    typedef logic [CNT_W-1:0]         t_cnt;

    typedef struct packed {
        t_word value;
        logic  last_item;
    } t_in;

    typedef struct packed {
        t_word sorted_value;
        logic  last_result;
    } t_out;

    typedef struct packed {
        logic  we;
        t_addr addr;
        t_word data;
    } t_wr_port;

endpackage

// ===== rtl/hs_ram.sv =====
// ----------------------------------------------------------------------------
// hs_ram: element store
// One write port, one read port, read data registered.
// Read and write of the same entry in one cycle returns the old contents.
// ----------------------------------------------------------------------------
module hs_ram (
    input  logic             i_clk,
    input  hs_pkg::t_wr_port i_wr,
    input  hs_pkg::t_addr    i_raddr,
    output hs_pkg::t_word    o_rdata
);

    hs_pkg::t_word mem [hs_pkg::CAPACITY];
    hs_pkg::t_word r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_wr.we) begin
            mem[i_wr.addr] <= i_wr.data;
        end
        r_rdata <= mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/heap_sorter.sv =====
// ----------------------------------------------------------------------------
// heap_sorter: in-place heapsort of up to CAPACITY signed 32-bit values
// Load: one beat per cycle, no result. Sort: heap build, then N-1 root
// extractions, each sift level a left-child read, a right-child read and
// a compare through the one read port. Output: N beats on consecutive
// cycles, smallest first, once the sort ends; the receiver cannot stall.
// Synchronous active-low reset clears the count and control; the store
// is not cleared.
// ----------------------------------------------------------------------------
module heap_sorter (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          start,
    input  hs_pkg::t_in   i_item,
    output logic          busy,
    output logic          o_valid,
    output hs_pkg::t_out  o_result
);

    typedef enum logic [3:0] {
        S_IDLE, S_BUILD, S_GETP, S_STEP, S_RDR, S_CMP,
        S_X0, S_X1, S_X2, S_OUT
    } t_state;

    t_state           r_state;
    hs_pkg::t_cnt     r_cnt;
    hs_pkg::t_cnt     r_n;
    hs_pkg::t_cnt     r_hlen;
    hs_pkg::t_addr    r_idx;
    hs_pkg::t_addr    r_p;
    hs_pkg::t_word    r_pval;
    hs_pkg::t_word    r_lval;
    hs_pkg::t_word    r_top;
    logic             r_build;
    logic             r_valid;
    logic             r_olast;

    hs_pkg::t_wr_port wr;
    hs_pkg::t_addr    raddr;
    hs_pkg::t_word    rdata;

    hs_ram u_ram (
        .i_clk   (i_clk),
        .i_wr    (wr),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    // child indexes of the current node
    logic [hs_pkg::CNT_W-1:0] left;
    logic [hs_pkg::CNT_W:0]   right;
    logic                     has_l;
    logic                     has_r;
    logic                     big_is_r;
    hs_pkg::t_word            bval;
    hs_pkg::t_addr            big_idx;
    logic                     move;
    logic                     set_end;
    logic                     out_last;

    assign left     = {r_p, 1'b1};
    assign right    = {1'b0, left} + (hs_pkg::CNT_W+1)'(1);
    assign has_l    = left < r_hlen;
    assign has_r    = right < {1'b0, r_hlen};
    assign big_is_r = has_r && (rdata > r_lval);
    assign bval     = big_is_r ? rdata : r_lval;
    assign big_idx  = big_is_r ? right[hs_pkg::ADDR_W-1:0] : left[hs_pkg::ADDR_W-1:0];
    assign move     = bval > r_pval;
    assign set_end  = i_item.last_item
                      || (r_cnt + hs_pkg::CNT_W'(1) == hs_pkg::CNT_W'(hs_pkg::CAPACITY));
    assign out_last = {1'b0, r_idx} == r_n - hs_pkg::CNT_W'(1);

    // where to go once a sift has finished
    t_state        sd_state;
    hs_pkg::t_addr sd_idx;
    logic          sd_build;

    always_comb begin
        sd_build = r_build;
        sd_idx   = r_idx - hs_pkg::ADDR_W'(1);
        sd_state = S_BUILD;
        if (r_build) begin
            if (r_idx == '0) begin
                sd_build = 1'b0;
                if (r_n == hs_pkg::CNT_W'(1)) begin
                    sd_idx   = '0;
                    sd_state = S_OUT;
                end else begin
                    sd_idx   = hs_pkg::ADDR_W'(r_n - hs_pkg::CNT_W'(1));
                    sd_state = S_X0;
                end
            end
        end else if (r_idx == hs_pkg::ADDR_W'(1)) begin
            sd_idx   = '0;
            sd_state = S_OUT;
        end else begin
            sd_state = S_X0;
        end
    end

    // store port control
    always_comb begin
        wr.we   = 1'b0;
        wr.addr = r_p;
        wr.data = r_pval;
        raddr   = r_p;
        unique case (r_state)
            S_IDLE: begin
                wr.we   = start;
                wr.addr = r_cnt[hs_pkg::ADDR_W-1:0];
                wr.data = i_item.value;
            end
            S_BUILD: raddr = r_idx;
            S_GETP:  raddr = r_p;
            S_STEP: begin
                if (has_l) begin
                    raddr = left[hs_pkg::ADDR_W-1:0];
                end else begin
                    wr.we = 1'b1;
                end
            end
            S_RDR: raddr = right[hs_pkg::ADDR_W-1:0];
            S_CMP: begin
                wr.we   = 1'b1;
                wr.data = move ? bval : r_pval;
            end
            S_X0: raddr = '0;
            S_X1: raddr = r_idx;
            S_X2: begin
                wr.we   = 1'b1;
                wr.addr = r_idx;
                wr.data = r_top;
            end
            S_OUT: raddr = r_idx;
            default: raddr = r_p;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
            r_build <= 1'b0;
            r_valid <= 1'b0;
        end else begin
            r_valid <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (start) begin
                        if (set_end) begin
                            r_n     <= r_cnt + hs_pkg::CNT_W'(1);
                            r_hlen  <= r_cnt + hs_pkg::CNT_W'(1);
                            r_idx   <= r_cnt[hs_pkg::CNT_W-1:1];  // (n-1)/2
                            r_build <= 1'b1;
                            r_cnt   <= '0;
                            r_state <= S_BUILD;
                        end else begin
                            r_cnt <= r_cnt + hs_pkg::CNT_W'(1);
                        end
                    end
                end
                S_BUILD: begin
                    r_p     <= r_idx;
                    r_state <= S_GETP;
                end
                S_GETP: begin
                    r_pval  <= rdata;
                    r_state <= S_STEP;
                end
                S_STEP: begin
                    if (has_l) begin
                        r_state <= S_RDR;
                    end else begin
                        r_idx   <= sd_idx;
                        r_build <= sd_build;
                        r_state <= sd_state;
                    end
                end
                S_RDR: begin
                    r_lval  <= rdata;
                    r_state <= S_CMP;
                end
                S_CMP: begin
                    // sifted value stays in r_pval; child moves up into p
                    if (move) begin
                        r_p     <= big_idx;
                        r_state <= S_STEP;
                    end else begin
                        r_idx   <= sd_idx;
                        r_build <= sd_build;
                        r_state <= sd_state;
                    end
                end
                S_X0: r_state <= S_X1;
                S_X1: begin
                    r_top   <= rdata;
                    r_state <= S_X2;
                end
                S_X2: begin
                    r_pval  <= rdata;
                    r_p     <= '0;
                    r_hlen  <= {1'b0, r_idx};
                    r_state <= S_STEP;
                end
                S_OUT: begin
                    r_valid <= 1'b1;
                    r_olast <= out_last;
                    r_idx   <= r_idx + hs_pkg::ADDR_W'(1);
                    if (out_last) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign busy                  = r_state != S_IDLE;
    assign o_valid               = r_valid;
    assign o_result.sorted_value = rdata;
    assign o_result.last_result  = r_olast;

    // more beats of the set follow, so the block cannot be taking items
    a_busy_mid_set: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_result.last_result) |-> busy)
        else $error("result beat before end of set while idle");

    a_last_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_result.last_result) |=> !o_valid)
        else $error("result beat right after final beat");

    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt < hs_pkg::CNT_W'(hs_pkg::CAPACITY))
        else $error("element count reached capacity while loading");

    a_no_result_on_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && !set_end) |=> !o_valid)
        else $error("result beat after a loading item");

endmodule

// ===== tb/heap_sorter_tb.sv =====
// ----------------------------------------------------------------------------
// heap_sorter_tb: self-checking bench for the heap sorter
// Loads sets of signed values through the start/busy port and predicts the
// ascending output of each set. Every output beat is checked against the
// oldest predicted value and its last flag. Sets cover single elements,
// extremes, duplicates and store-full sets with and without the last flag.
// ----------------------------------------------------------------------------
module heap_sorter_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int RAND_ITEMS = 450;
    localparam int QUIET_TAIL = 60;     // final beats sent without gaps
    localparam int DRAIN_WAIT = 32;
    localparam int CYCLE_LIMIT = 400000;

    // Predicts each set's sorted output and checks the result beats.
    class sorted_set_board;
        hs_pkg::t_word store[hs_pkg::CAPACITY];
        int            count;
        hs_pkg::t_out  sorted_q[$];
        int            mismatches;
        int            results_checked;
        int            sets_done;
        int            largest_set;

        function new();
            count = 0;
            mismatches = 0;
            results_checked = 0;
            sets_done = 0;
            largest_set = 0;
        endfunction

        function int pending();
            return sorted_q.size();
        endfunction

        function void note_item(hs_pkg::t_in beat);
            hs_pkg::t_word srt[hs_pkg::CAPACITY];
            hs_pkg::t_word key;
            hs_pkg::t_out  res;
            int            i;
            int            j;
            if (count >= hs_pkg::CAPACITY)
                count = 0;
            store[count] = beat.value;
            count++;
            if (!beat.last_item && count < hs_pkg::CAPACITY)
                return;
            for (i = 0; i < count; i++)
                srt[i] = store[i];
            // equal values are indistinguishable, so any sort gives the same beats
            for (i = 1; i < count; i++) begin
                key = srt[i];
                j = i - 1;
                while (j >= 0 && srt[j] > key) begin
                    srt[j + 1] = srt[j];
                    j--;
                end
                srt[j + 1] = key;
            end
            for (i = 0; i < count; i++) begin
                res.sorted_value = srt[i];
                res.last_result = (i == count - 1);
                sorted_q.push_back(res);
            end
            sets_done++;
            if (count > largest_set)
                largest_set = count;
            count = 0;
        endfunction

        function void check_result(hs_pkg::t_out got);
            hs_pkg::t_out want;
            if (sorted_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("%0t: unexpected result value=%0d last=%0b",
                             $realtime, got.sorted_value, got.last_result);
                return;
            end
            want = sorted_q.pop_front();
            results_checked++;
            if (got.sorted_value !== want.sorted_value ||
                got.last_result !== want.last_result) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("%0t: mismatch exp value=%0d last=%0b, got value=%0d last=%0b",
                             $realtime, want.sorted_value, want.last_result,
                             got.sorted_value, got.last_result);
            end
        endfunction
    endclass

    logic         i_clk   = 1'b0;
    logic         i_rst_n = 1'b0;
    logic         start   = 1'b0;
    hs_pkg::t_in  i_item  = '0;
    logic         busy;
    logic         o_valid;
    hs_pkg::t_out o_result;

    sorted_set_board sort_board;
    int            cycles      = 0;
    int            beats_sent  = 0;
    int            rand_items  = 0;
    bit            gaps_on     = 1'b1;
    hs_pkg::t_word recent_value = '0;

    heap_sorter u_dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .i_item   (i_item),
        .busy     (busy),
        .o_valid  (o_valid),
        .o_result (o_result)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // Reads pre-edge values, so the block's own updates at this edge never race.
    always @(posedge i_clk) begin
        if (i_rst_n && start && !busy)
            sort_board.note_item(i_item);
        if (i_rst_n && o_valid)
            sort_board.check_result(o_result);
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles, %0d results outstanding",
                     cycles, sort_board.pending());
            $display("== FAIL ==");
            $finish;
        end
    end

    task automatic send_beat(input hs_pkg::t_word v, input logic last);
        hs_pkg::t_in beat;
        beat.value = v;
        beat.last_item = last;
        start <= 1'b1;
        i_item <= beat;
        @(posedge i_clk);
        while (busy)
            @(posedge i_clk);
        beats_sent++;
    endtask

    task automatic idle(input int n);
        start <= 1'b0;
        repeat (n) @(posedge i_clk);
    endtask

    // Hold off until every predicted beat has come out.
    task automatic drain();
        start <= 1'b0;
        @(posedge i_clk);
        while (sort_board.pending() != 0)
            @(posedge i_clk);
    endtask

    function automatic hs_pkg::t_word pick_value();
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4, 5: return $urandom;
            6: return int'($urandom_range(0, 16)) - 8;
            7: return $urandom_range(0, 1) ? 32'sh7FFFFFFF : 32'sh80000000;
            8: return recent_value;
            default: return $urandom_range(0, 1) ?
                            32'sh7FFFFFFF - int'($urandom_range(0, 3)) :
                            32'sh80000000 + int'($urandom_range(0, 3));
        endcase
    endfunction

    task automatic send_set(input int size, input bit last_on_full);
        hs_pkg::t_word v;
        logic          last;
        int            k;
        for (k = 0; k < size; k++) begin
            v = pick_value();
            recent_value = v;
            if (k == size - 1)
                last = (size == hs_pkg::CAPACITY) ? last_on_full : 1'b1;
            else
                last = 1'b0;
            send_beat(v, last);
            rand_items++;
            if (rand_items >= RAND_ITEMS - QUIET_TAIL)
                gaps_on = 1'b0;
            if (gaps_on && $urandom_range(0, 4) == 0)
                idle($urandom_range(1, 9));
        end
    endtask

    initial begin
        int size;
        int sel;
        sort_board = new();

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // single-element set at the top of the range
        send_beat(32'sh7FFFFFFF, 1'b1);
        // extremes and values around zero
        send_beat(32'sh80000000, 1'b0);
        send_beat(32'sh7FFFFFFF, 1'b0);
        send_beat(32'sh00000000, 1'b0);
        send_beat(-32'sd1, 1'b0);
        send_beat(32'sd1, 1'b1);
        drain();
        // duplicates
        send_beat(32'sd7, 1'b0);
        send_beat(32'sd7, 1'b0);
        send_beat(-32'sd7, 1'b0);
        send_beat(32'sd7, 1'b1);
        idle($urandom_range(1, 9));
        // already descending
        send_beat(32'sd100, 1'b0);
        send_beat(32'sd50, 1'b0);
        send_beat(32'sd0, 1'b0);
        send_beat(-32'sd50, 1'b0);
        send_beat(-32'sd100, 1'b1);
        // two copies of the minimum
        send_beat(32'sh80000000, 1'b0);
        send_beat(32'sh80000000, 1'b1);

        // store filled without a last flag, then one set ending at capacity - 1
        send_set(hs_pkg::CAPACITY, 1'b0);
        drain();
        send_set(hs_pkg::CAPACITY - 1, 1'b1);

        while (rand_items < RAND_ITEMS) begin
            sel = $urandom_range(0, 99);
            if (sel < 85)
                size = $urandom_range(1, 10);
            else if (sel < 95)
                size = $urandom_range(11, 40);
            else
                size = $urandom_range(hs_pkg::CAPACITY - 4, hs_pkg::CAPACITY);
            send_set(size, $urandom_range(0, 1));
            if (gaps_on && $urandom_range(0, 7) == 0)
                drain();
        end

        drain();
        repeat (DRAIN_WAIT) @(posedge i_clk);

        $display("Sorted %0d sets from %0d beats, %0d results checked, largest set %0d.",
                 sort_board.sets_done, beats_sent, sort_board.results_checked,
                 sort_board.largest_set);
        $display("Covered range extremes, duplicates, one-element and store-full sets.");
        if (sort_board.mismatches == 0 && sort_board.pending() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("%0d mismatches, %0d results never seen",
                     sort_board.mismatches, sort_board.pending());
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
